// ----- rtl/core/prtc_pkg.sv -----
// Shared types and constants of the point rigid transform and colormap unit.
package prtc_pkg;

    localparam int COEF_W         = 32;
    localparam int COORD_W        = 32;
    localparam int COLOR_W        = 8;
    localparam int IDX_W          = 4;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 8;
    localparam int NUM_COEF       = 12;
    localparam int NUM_ROT        = 9;
    localparam int COEF_FRAC_BITS = 30;
    localparam int PROD_W         = COEF_W + COORD_W;
    localparam int SUM_W          = PROD_W + 2;
    localparam int ACC_W          = SUM_W + 1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOUD_ROLE = 4'd1;

    localparam logic [IDX_W-1:0] LAST_COEF_IDX = 4'd11;
    localparam logic [COEF_W-1:0] COEF_ONE = 32'h4000_0000;

    typedef struct packed {
        logic                      is_point;
        logic [IDX_W-1:0]          coef_index;
        logic signed [COEF_W-1:0]  coef_value;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [COLOR_W-1:0]        intensity;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ----- rtl/core/prtc_front.sv -----
// Front end: accepts input transactions, classifies them and drops invalid loads.
module prtc_front (
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic [prtc_pkg::IDX_W-1:0]          i_coef_index,
    input  logic signed [prtc_pkg::COEF_W-1:0]  i_coef_value,
    input  logic signed [prtc_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [prtc_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [prtc_pkg::COORD_W-1:0] i_point_z,
    input  logic [prtc_pkg::COLOR_W-1:0]        i_intensity,
    input  prtc_pkg::t_queue_status             i_qstat,
    output logic                                o_push,
    output prtc_pkg::t_item                     o_item
);

    logic w_keep;

    assign w_keep = (i_command == prtc_pkg::CMD_POINT) ||
                    (i_coef_index <= prtc_pkg::LAST_COEF_IDX);

    assign o_stall = i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full && w_keep;

    always_comb begin
        o_item.is_point   = (i_command == prtc_pkg::CMD_POINT);
        o_item.coef_index = i_coef_index;
        o_item.coef_value = i_coef_value;
        o_item.point_x    = i_point_x;
        o_item.point_y    = i_point_y;
        o_item.point_z    = i_point_z;
        o_item.intensity  = i_intensity;
    end

endmodule

// ----- rtl/core/prtc_queue.sv -----
// Short FIFO that decouples the front end from the transform back end.
module prtc_queue #(
    parameter int DEPTH = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  prtc_pkg::t_item         i_item,
    input  logic                    i_pop,
    output prtc_pkg::t_item         o_item,
    output prtc_pkg::t_queue_status o_qstat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    prtc_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item        = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == CNT_W'(DEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

// ----- rtl/core/prtc_back.sv -----
// Back end: coefficient store, three-stage transform pipeline and point coloring.
module prtc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [prtc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [prtc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  prtc_pkg::t_item                     i_item,
    input  prtc_pkg::t_queue_status             i_qstat,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [prtc_pkg::COORD_W-1:0] o_out_x,
    output logic signed [prtc_pkg::COORD_W-1:0] o_out_y,
    output logic signed [prtc_pkg::COORD_W-1:0] o_out_z,
    output logic [prtc_pkg::COLOR_W-1:0]        o_red,
    output logic [prtc_pkg::COLOR_W-1:0]        o_green,
    output logic [prtc_pkg::COLOR_W-1:0]        o_blue
);

    localparam int CW = prtc_pkg::COLOR_W;

    logic r_color_mode;
    logic r_cloud_role;

    logic signed [prtc_pkg::COEF_W-1:0]  r_coef [prtc_pkg::NUM_COEF];
    logic signed [prtc_pkg::COORD_W-1:0] w_pt [3];

    logic                                r_v1, r_v2, r_v3;
    logic                                w_en1, w_en2, w_en3;
    logic signed [prtc_pkg::PROD_W-1:0]  r_prod [prtc_pkg::NUM_ROT];
    logic signed [prtc_pkg::PROD_W-1:0]  n_prod [prtc_pkg::NUM_ROT];
    logic signed [prtc_pkg::COEF_W-1:0]  r_t1 [3];
    logic signed [prtc_pkg::COEF_W-1:0]  r_t2 [3];
    logic signed [prtc_pkg::SUM_W-1:0]   r_sum [3];
    logic signed [prtc_pkg::SUM_W-1:0]   n_sum [3];
    logic signed [prtc_pkg::SUM_W-1:0]   w_shift [3];
    logic signed [prtc_pkg::ACC_W-1:0]   w_acc [3];
    logic signed [prtc_pkg::COORD_W-1:0] n_out [3];
    logic signed [prtc_pkg::COORD_W-1:0] r_out [3];
    logic [3*CW-1:0]                     n_rgb, r_rgb1, r_rgb2, r_rgb3;
    logic [CW-1:0]                       w_cm_r, w_cm_g, w_cm_b;
    logic [CW-1:0]                       w_v;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= 1'b0;
            r_cloud_role <= 1'b1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == prtc_pkg::CFG_COLOR_MODE) begin
                r_color_mode <= i_cfg_data[0];
            end else if (i_cfg_index == prtc_pkg::CFG_CLOUD_ROLE) begin
                r_cloud_role <= i_cfg_data[0];
            end
        end
    end

    assign w_en3 = !r_v3 || !i_stall;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign o_pop = !i_qstat.empty && w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < prtc_pkg::NUM_COEF; k++) begin
                r_coef[k] <= (k < prtc_pkg::NUM_ROT && k % 4 == 0) ? prtc_pkg::COEF_ONE : '0;
            end
        end else if (o_pop && !i_item.is_point) begin
            r_coef[i_item.coef_index] <= i_item.coef_value;
        end
    end

    assign w_pt[0] = i_item.point_x;
    assign w_pt[1] = i_item.point_y;
    assign w_pt[2] = i_item.point_z;
    assign w_v     = i_item.intensity;

    always_comb begin
        for (int k = 0; k < prtc_pkg::NUM_ROT; k++) begin
            n_prod[k] = $signed(r_coef[k]) * $signed(w_pt[k % 3]);
        end
    end

    always_comb begin
        if (!w_v[7]) begin
            w_cm_r = '0;
        end else if (!w_v[6]) begin
            w_cm_r = CW'(3 * w_v[5:0]);
        end else begin
            w_cm_r = 8'd255;
        end
        if (w_v[7:6] == 2'b00) begin
            w_cm_g = CW'(3 * w_v[5:0]);
        end else if (w_v[7:6] != 2'b11) begin
            w_cm_g = 8'd255;
        end else begin
            w_cm_g = 8'd255 - {w_v[5:0], 2'b00};
        end
        if (w_v[7:6] == 2'b00) begin
            w_cm_b = 8'd255;
        end else if (w_v[7:6] == 2'b01) begin
            w_cm_b = 8'd255 - {w_v[5:0], 2'b00};
        end else begin
            w_cm_b = '0;
        end
        if (r_color_mode) begin
            n_rgb = r_cloud_role ? {w_cm_r, w_cm_b, w_cm_g} : {w_cm_r, w_cm_g, w_cm_b};
        end else begin
            n_rgb = r_cloud_role ? {w_v, 8'd0, 8'd0} : {w_v, w_v, w_v};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = prtc_pkg::SUM_W'(r_prod[3*i])
                     + prtc_pkg::SUM_W'(r_prod[3*i+1])
                     + prtc_pkg::SUM_W'(r_prod[3*i+2]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_shift[i] = r_sum[i] >>> prtc_pkg::COEF_FRAC_BITS;
            w_acc[i]   = prtc_pkg::ACC_W'(w_shift[i]) + prtc_pkg::ACC_W'(r_t2[i]);
            if (!w_acc[i][prtc_pkg::ACC_W-1] && (|w_acc[i][prtc_pkg::ACC_W-2:31])) begin
                n_out[i] = 32'sh7FFF_FFFF;
            end else if (w_acc[i][prtc_pkg::ACC_W-1] &&
                         !(&w_acc[i][prtc_pkg::ACC_W-2:31])) begin
                n_out[i] = 32'sh8000_0000;
            end else begin
                n_out[i] = w_acc[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= o_pop && i_item.is_point;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            for (int k = 0; k < prtc_pkg::NUM_ROT; k++) begin
                r_prod[k] <= n_prod[k];
            end
            for (int i = 0; i < 3; i++) begin
                r_t1[i] <= r_coef[prtc_pkg::NUM_ROT + i];
            end
            r_rgb1 <= n_rgb;
        end
        if (w_en2) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= n_sum[i];
                r_t2[i]  <= r_t1[i];
            end
            r_rgb2 <= r_rgb1;
        end
        if (w_en3) begin
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= n_out[i];
            end
            r_rgb3 <= r_rgb2;
        end
    end

    assign o_valid = r_v3;
    assign o_out_x = r_out[0];
    assign o_out_y = r_out[1];
    assign o_out_z = r_out[2];
    assign o_red   = r_rgb3[3*CW-1:2*CW];
    assign o_green = r_rgb3[2*CW-1:CW];
    assign o_blue  = r_rgb3[CW-1:0];

endmodule

// ----- rtl/core/point_rigid_transform_colormap_unit.sv -----
// Top level of the point rigid transform and colormap unit.
// Path: a point transaction passes through the queue and then the product, sum and output
// registers of the back end; load transactions produce no result.
// Throughput: one transaction per cycle through the pipelined multiply, sum and saturate
// stages of the back end while i_stall is low; the input stalls only while the queue is full.
// Reset: synchronous, active low; identity coefficients, plain moved-cloud coloring, empty queue.
module point_rigid_transform_colormap_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic [prtc_pkg::IDX_W-1:0]          i_coef_index,
    input  logic signed [prtc_pkg::COEF_W-1:0]  i_coef_value,
    input  logic signed [prtc_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [prtc_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [prtc_pkg::COORD_W-1:0] i_point_z,
    input  logic [prtc_pkg::COLOR_W-1:0]        i_intensity,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [prtc_pkg::COORD_W-1:0] o_out_x,
    output logic signed [prtc_pkg::COORD_W-1:0] o_out_y,
    output logic signed [prtc_pkg::COORD_W-1:0] o_out_z,
    output logic [prtc_pkg::COLOR_W-1:0]        o_red,
    output logic [prtc_pkg::COLOR_W-1:0]        o_green,
    output logic [prtc_pkg::COLOR_W-1:0]        o_blue,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [prtc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [prtc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    prtc_pkg::t_queue_status w_qstat;
    prtc_pkg::t_item         w_in_item;
    prtc_pkg::t_item         w_head_item;
    logic                    w_push;
    logic                    w_pop;

    prtc_front u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .i_intensity  (i_intensity),
        .i_qstat      (w_qstat),
        .o_push       (w_push),
        .o_item       (w_in_item)
    );

    prtc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_qstat (w_qstat)
    );

    prtc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_head_item),
        .i_qstat     (w_qstat),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the point rigid transform and colormap unit.
module tb;

    typedef struct {
        logic signed [prtc_pkg::COORD_W-1:0] x;
        logic signed [prtc_pkg::COORD_W-1:0] y;
        logic signed [prtc_pkg::COORD_W-1:0] z;
        logic [prtc_pkg::COLOR_W-1:0]        red;
        logic [prtc_pkg::COLOR_W-1:0]        green;
        logic [prtc_pkg::COLOR_W-1:0]        blue;
    } t_colored_point;

    localparam logic signed [67:0] COORD_MAX = 68'sd2147483647;
    localparam logic signed [67:0] COORD_MIN = -68'sd2147483648;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_valid = 1'b0;
    logic                                  o_stall;
    logic                                  i_command = prtc_pkg::CMD_LOAD;
    logic [prtc_pkg::IDX_W-1:0]            i_coef_index = '0;
    logic signed [prtc_pkg::COEF_W-1:0]    i_coef_value = '0;
    logic signed [prtc_pkg::COORD_W-1:0]   i_point_x = '0;
    logic signed [prtc_pkg::COORD_W-1:0]   i_point_y = '0;
    logic signed [prtc_pkg::COORD_W-1:0]   i_point_z = '0;
    logic [prtc_pkg::COLOR_W-1:0]          i_intensity = '0;
    logic                                  o_valid;
    logic                                  i_stall = 1'b0;
    logic signed [prtc_pkg::COORD_W-1:0]   o_out_x;
    logic signed [prtc_pkg::COORD_W-1:0]   o_out_y;
    logic signed [prtc_pkg::COORD_W-1:0]   o_out_z;
    logic [prtc_pkg::COLOR_W-1:0]          o_red;
    logic [prtc_pkg::COLOR_W-1:0]          o_green;
    logic [prtc_pkg::COLOR_W-1:0]          o_blue;
    logic                                  i_cfg_valid = 1'b0;
    logic                                  o_cfg_ready;
    logic [prtc_pkg::CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [prtc_pkg::CFG_DATA_W-1:0]       i_cfg_data = '0;

    logic signed [prtc_pkg::COEF_W-1:0] coef_mem [prtc_pkg::NUM_COEF];
    logic                               color_mode;
    logic                               cloud_role;
    t_colored_point                     expected_points [$];
    t_colored_point                     oldest;
    int                                 error_count = 0;
    int                                 stall_hold = 0;
    int                                 stall_roll;
    logic                               steady_flow = 1'b0;
    int                                 band_edges [8] = '{0, 63, 64, 127, 128, 191, 192, 255};

    point_rigid_transform_colormap_unit dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #24_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_colored_point expected_point(input prtc_pkg::t_item it);
        t_colored_point res;
        logic signed [prtc_pkg::COORD_W-1:0] p [3];
        logic signed [prtc_pkg::COORD_W-1:0] coord [3];
        logic signed [67:0] acc;
        int row;
        int v;
        int r;
        int g;
        int b;
        int t;
        p[0] = it.point_x;
        p[1] = it.point_y;
        p[2] = it.point_z;
        for (row = 0; row < 3; row++) begin
            acc = coef_mem[row*3] * p[0] + coef_mem[row*3+1] * p[1]
                + coef_mem[row*3+2] * p[2];
            acc = acc >>> prtc_pkg::COEF_FRAC_BITS;
            acc = acc + coef_mem[prtc_pkg::NUM_ROT+row];
            if (acc > COORD_MAX) begin
                acc = COORD_MAX;
            end else if (acc < COORD_MIN) begin
                acc = COORD_MIN;
            end
            coord[row] = acc[prtc_pkg::COORD_W-1:0];
        end
        v = it.intensity;
        if (color_mode) begin
            r = (v < 128) ? 0 : (v < 192) ? 3 * (v - 128) : 255;
            g = (v < 64) ? 3 * v : (v < 192) ? 255 : 255 - 4 * (v - 192);
            b = (v < 64) ? 255 : (v < 128) ? 255 - 4 * (v - 64) : 0;
            if (cloud_role) begin
                t = g;
                g = b;
                b = t;
            end
        end else if (cloud_role) begin
            r = v;
            g = 0;
            b = 0;
        end else begin
            r = v;
            g = v;
            b = v;
        end
        res.x = coord[0];
        res.y = coord[1];
        res.z = coord[2];
        res.red = r[prtc_pkg::COLOR_W-1:0];
        res.green = g[prtc_pkg::COLOR_W-1:0];
        res.blue = b[prtc_pkg::COLOR_W-1:0];
        return res;
    endfunction

    function automatic logic [31:0] pick_rotation();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return 32'(longint'($urandom_range(0, 32'h8000_0000))
                       - longint'(prtc_pkg::COEF_ONE));
        end else if (r < 9) begin
            return $urandom();
        end
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return prtc_pkg::COEF_ONE;
        endcase
    endfunction

    function automatic logic [31:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            return 32'(longint'($urandom_range(0, 32'h0100_0000)) - 64'sh0080_0000);
        end else if (r < 9) begin
            return $urandom();
        end
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic prtc_pkg::t_item make_point(input logic [31:0] x,
                                                   input logic [31:0] y,
                                                   input logic [31:0] z, input int level);
        prtc_pkg::t_item it;
        it.is_point = prtc_pkg::CMD_POINT;
        it.coef_index = prtc_pkg::IDX_W'($urandom());
        it.coef_value = $urandom();
        it.point_x = x;
        it.point_y = y;
        it.point_z = z;
        it.intensity = prtc_pkg::COLOR_W'(level);
        return it;
    endfunction

    function automatic prtc_pkg::t_item make_load(input int idx, input logic [31:0] value);
        prtc_pkg::t_item it;
        it.is_point = prtc_pkg::CMD_LOAD;
        it.coef_index = prtc_pkg::IDX_W'(idx);
        it.coef_value = value;
        it.point_x = $urandom();
        it.point_y = $urandom();
        it.point_z = $urandom();
        it.intensity = prtc_pkg::COLOR_W'($urandom());
        return it;
    endfunction

    function automatic int idle_len();
        int r;
        if (steady_flow) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic send_item(input prtc_pkg::t_item it);
        int gap;
        gap = idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_command = it.is_point;
        i_coef_index = it.coef_index;
        i_coef_value = it.coef_value;
        i_point_x = it.point_x;
        i_point_y = it.point_y;
        i_point_z = it.point_z;
        i_intensity = it.intensity;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        if (it.is_point == prtc_pkg::CMD_POINT) begin
            expected_points.insert(expected_points.size(), expected_point(it));
        end else if (it.coef_index <= prtc_pkg::LAST_COEF_IDX) begin
            coef_mem[it.coef_index] = it.coef_value;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [prtc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = {7'($urandom()), value};
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == prtc_pkg::CFG_COLOR_MODE) begin
            color_mode = i_cfg_data[0];
        end else if (idx == prtc_pkg::CFG_CLOUD_ROLE) begin
            cloud_role = i_cfg_data[0];
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Reset state: identity rotation, plain coloring, moved-cloud role.
    task automatic test_reset_passthrough();
        send_item(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 255));
        send_item(make_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678, 0));
        send_item(make_point(pick_coord(), pick_coord(), pick_coord(), 8'h5A));
    endtask

    task automatic test_coefficient_loads();
        send_item(make_load(0, 32'h7FFF_FFFF));
        send_item(make_load(9, 32'h7FFF_FFFF));
        send_item(make_load(12, 32'h0000_0000));
        send_item(make_load(15, 32'h8000_0000));
        send_item(make_load(4, 32'h8000_0000));
        send_item(make_load(11, 32'hFFFF_FFFF));
        send_item(make_load(2, 32'h0000_0001));
        send_item(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 17));
        send_item(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 200));
        send_item(make_load(0, prtc_pkg::COEF_ONE));
        send_item(make_load(4, prtc_pkg::COEF_ONE));
        send_item(make_load(2, 32'h0000_0000));
        send_item(make_load(9, 32'h0000_0000));
        send_item(make_load(11, 32'h0000_0000));
    endtask

    task automatic test_color_schemes();
        int combo;
        int k;
        for (combo = 0; combo < 4; combo++) begin
            write_register(prtc_pkg::CFG_COLOR_MODE, combo[0]);
            write_register(prtc_pkg::CFG_CLOUD_ROLE, combo[1]);
            write_register(prtc_pkg::CFG_IDX_W'($urandom_range(2, 15)), 1'($urandom()));
            for (k = 0; k < 3; k++) begin
                send_item(make_point(pick_coord(), pick_coord(), pick_coord(),
                                     band_edges[(combo * 3 + k) % 8]));
            end
        end
    endtask

    task automatic test_random_stream();
        int phase;
        int n;
        int idx;
        logic [1:0] setting;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: setting = 2'b00;
                1: setting = 2'b11;
                2: setting = 2'b01;
                3: setting = 2'b10;
                default: setting = 2'($urandom());
            endcase
            write_register(prtc_pkg::CFG_COLOR_MODE, setting[0]);
            write_register(prtc_pkg::CFG_CLOUD_ROLE, setting[1]);
            write_register(prtc_pkg::CFG_IDX_W'($urandom_range(2, 15)), 1'($urandom()));
            for (idx = 0; idx < prtc_pkg::NUM_COEF; idx++) begin
                send_item(make_load(idx, (idx < prtc_pkg::NUM_ROT) ? pick_rotation()
                                                                     : pick_coord()));
            end
            for (n = 0; n < 175; n++) begin
                steady_flow = (n >= 60 && n < 100);
                if (phase == 2 && n == 120) begin
                    wait_drained();
                end
                if ($urandom_range(0, 99) < 10) begin
                    idx = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 11)
                                                        : $urandom_range(12, 15);
                    send_item(make_load(idx, (idx < prtc_pkg::NUM_ROT) ? pick_rotation()
                                                                         : pick_coord()));
                end else begin
                    send_item(make_point(pick_coord(), pick_coord(), pick_coord(),
                                         $urandom_range(0, 255)));
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold = stall_hold - 1;
        end else if (steady_flow) begin
            i_stall = 1'b0;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 65) begin
                i_stall = 1'b0;
            end else if (stall_roll < 93) begin
                i_stall = 1'b1;
                stall_hold = $urandom_range(0, 2);
            end else begin
                i_stall = 1'b1;
                stall_hold = $urandom_range(10, 30);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_points.size() == 0) begin
                $display("%0t: result transaction with no point outstanding", $time);
                error_count++;
            end else begin
                oldest = expected_points.pop_front();
                compare_field("out_x", oldest.x, o_out_x);
                compare_field("out_y", oldest.y, o_out_y);
                compare_field("out_z", oldest.z, o_out_z);
                compare_field("red", oldest.red, o_red);
                compare_field("green", oldest.green, o_green);
                compare_field("blue", oldest.blue, o_blue);
            end
        end
    end

    initial begin
        for (int i = 0; i < prtc_pkg::NUM_COEF; i++) begin
            coef_mem[i] = '0;
        end
        coef_mem[0] = prtc_pkg::COEF_ONE;
        coef_mem[4] = prtc_pkg::COEF_ONE;
        coef_mem[8] = prtc_pkg::COEF_ONE;
        color_mode = 1'b0;
        cloud_role = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_passthrough();
        test_coefficient_loads();
        test_color_schemes();
        test_random_stream();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/prtc_pkg.sv
rtl/core/prtc_front.sv
rtl/core/prtc_queue.sv
rtl/core/prtc_back.sv
rtl/core/point_rigid_transform_colormap_unit.sv
sim/tb.sv
